// ===== hdl/cssr_pkg.sv =====
// Shared types and constants of the CompactSize string reader.
// No dependencies; every other file depends on this package.
`default_nettype none

package cssr_pkg;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  // Tag bytes that open a long-form length
  localparam logic [7:0] TAG_U16 = 8'hFD;
  localparam logic [7:0] TAG_U32 = 8'hFE;
  localparam logic [7:0] TAG_U64 = 8'hFF;

  // Number of length bytes after each tag
  localparam logic [3:0] LEN_BYTES_U16 = 4'd2;
  localparam logic [3:0] LEN_BYTES_U32 = 4'd4;
  localparam logic [3:0] LEN_BYTES_U64 = 4'd8;

  localparam logic [30:0] LEN_SAT          = 31'h7FFF_FFFF;
  localparam logic [30:0] MAX_LENGTH_RESET = 31'd65535;

  // Register index of max_length, taken from paddr[2]
  localparam logic REG_MAX_LENGTH = 1'b0;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic        last;
    logic [30:0] len;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/cssr_if.sv =====
// Valid/ready channel interfaces of the CompactSize string reader.
// Depends on cssr_pkg for the result kind type.
`default_nettype none

interface cssr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface cssr_res_if;
  logic               valid;
  logic               ready;
  cssr_pkg::kind_t    kind;
  logic [7:0]         out_byte;
  logic               last;
  logic [30:0]        string_length;

  modport source (output valid, output kind, output out_byte, output last,
                  output string_length, input ready);
  modport sink   (input valid, input kind, input out_byte, input last,
                  input string_length, output ready);
endinterface

`default_nettype wire

// ===== hdl/compact_size_string_reader.sv =====
// Top level of the CompactSize string reader: parser, register port and
// output register. Depends on cssr_pkg, cssr_if, cssr_apb and cssr_parser.
//
// Usage:
//   in_chan carries the serialized stream, one byte per transfer. Each string
//   opens with a CompactSize length: a tag below 0xFD is the length, tags
//   0xFD/0xFE/0xFF are followed by 2/4/8 little-endian length bytes.
//   out_chan carries one result per payload byte (last marks the final one),
//   one empty-string result for a zero length, or one error result when the
//   length exceeds max_length. After an error the block drops every byte
//   until reset.
//   max_length is written over the APB-style port at address 0.
// Latency and throughput:
//   A result is presented in the cycle after the byte that causes it is taken.
//   Unless a held result stalls, the block takes one byte per cycle; the single
//   output register sets that rate by taking a byte as the held result leaves.
// Reset (synchronous, rst_n low): parser waits for a tag byte, output register
//   empties, max_length returns to 65535.
// Stall: while out_chan.ready is low and a result is held, in_chan.ready drops
//   and the held result stays unchanged.
`default_nettype none

module compact_size_string_reader (
  input  wire logic        clk,
  input  wire logic        rst_n,
  cssr_byte_if.sink        in_chan,
  cssr_res_if.source       out_chan,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import cssr_pkg::*;

  logic [30:0] max_length;
  logic        take;
  logic        res_valid;
  res_t        res;

  logic        out_valid_r;
  res_t        out_res_r;

  cssr_apb u_apb (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .max_length (max_length)
  );

  // Take a byte whenever the output register is empty or leaving this cycle
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign take          = in_chan.valid && in_chan.ready;

  cssr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .in_byte    (in_chan.in_byte),
    .max_length (max_length),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Output register: load a new result, drop the held one once transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= res_valid;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.kind          = out_res_r.kind;
  assign out_chan.out_byte      = out_res_r.data;
  assign out_chan.last          = out_res_r.last;
  assign out_chan.string_length = out_res_r.len;

  // Error and empty-string results always close a string
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.kind != KIND_PAYLOAD) |-> out_chan.last)
    else $error("error or empty result without last");

  // An empty string reports no byte and a zero length
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.kind == KIND_EMPTY) |->
      (out_chan.string_length == 31'd0) && (out_chan.out_byte == 8'd0))
    else $error("empty result with nonzero fields");

  // A payload byte belongs to a string of nonzero length
  a_pay_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.kind == KIND_PAYLOAD) |->
      (out_chan.string_length != 31'd0))
    else $error("payload byte with zero length");

  // Once the error result is taken, the stream stays stopped
  a_stop_after_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.ready && (out_chan.kind == KIND_ERROR) |=>
      !out_chan.valid)
    else $error("result after error");

endmodule

`default_nettype wire

// ===== hdl/cssr_apb.sv =====
// APB-style register port holding max_length.
// Depends on cssr_pkg for the register index and reset value.
`default_nettype none

module cssr_apb (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [30:0] max_length
);
  import cssr_pkg::*;

  logic [30:0] max_length_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_MAX_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LENGTH_RESET;
    end else if (wr_en) begin
      max_length_r <= pwdata[30:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_MAX_LENGTH) begin
      prdata = {1'b0, max_length_r};
    end
  end

  assign max_length = max_length_r;

endmodule

`default_nettype wire

// ===== hdl/cssr_parser.sv =====
// Length-prefix parser: phase state, length assembly and limit check.
// Depends on cssr_pkg for result types, tag codes and constants.
`default_nettype none

module cssr_parser (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           take,
  input  wire logic [7:0]     in_byte,
  input  wire logic [30:0]    max_length,
  output logic                res_valid,
  output cssr_pkg::res_t      res
);
  import cssr_pkg::*;

  typedef enum logic [1:0] {
    PH_TAG  = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2,
    PH_STOP = 2'd3
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [3:0]  total_r, total_nxt;
  logic [63:0] len_r, len_nxt;
  logic [30:0] remain_r, remain_nxt;

  logic [63:0] len_new;
  logic [2:0]  idx_inc;
  logic [30:0] remain_dec;
  logic        finish;
  logic        over;

  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    total_nxt  = total_r;
    len_nxt    = len_r;
    remain_nxt = remain_r;
    len_new    = len_r;
    finish     = 1'b0;
    res_valid  = 1'b0;
    res        = '{kind: KIND_PAYLOAD, data: 8'd0, last: 1'b0, len: 31'd0};
    idx_inc    = idx_r + 3'd1;
    remain_dec = remain_r - 31'd1;

    case (phase_r)
      PH_TAG: begin
        if (in_byte < TAG_U16) begin
          len_new = {56'd0, in_byte};
          finish  = 1'b1;
        end else begin
          case (in_byte)
            TAG_U16: total_nxt = LEN_BYTES_U16;
            TAG_U32: total_nxt = LEN_BYTES_U32;
            default: total_nxt = LEN_BYTES_U64;
          endcase
          idx_nxt   = 3'd0;
          len_nxt   = 64'd0;
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        // Merge the byte into its little-endian lane
        for (int k = 0; k < 8; k++) begin
          if (idx_r == 3'(k)) begin
            len_new[k*8 +: 8] = len_r[k*8 +: 8] | in_byte;
          end
        end
        len_nxt = len_new;
        idx_nxt = idx_inc;
        // Eight bytes wrap the index back to zero
        if (idx_inc == total_r[2:0]) begin
          idx_nxt = 3'd0;
          finish  = 1'b1;
        end
      end
      PH_PAY: begin
        remain_nxt = remain_dec;
        res_valid  = 1'b1;
        res.data   = in_byte;
        res.last   = (remain_dec == 31'd0);
        res.len    = len_r[30:0];
        if (remain_dec == 31'd0) begin
          phase_nxt = PH_TAG;
        end
      end
      default: begin
        // Stopped: drop the byte
      end
    endcase

    over = (|len_new[63:31]) || (len_new[30:0] > max_length);

    if (finish) begin
      len_nxt = len_new;
      if (over) begin
        phase_nxt = PH_STOP;
        res_valid = 1'b1;
        res.kind  = KIND_ERROR;
        res.last  = 1'b1;
        res.len   = (|len_new[63:31]) ? LEN_SAT : len_new[30:0];
      end else if (len_new[30:0] == 31'd0) begin
        phase_nxt = PH_TAG;
        res_valid = 1'b1;
        res.kind  = KIND_EMPTY;
        res.last  = 1'b1;
      end else begin
        phase_nxt  = PH_PAY;
        remain_nxt = len_new[30:0];
      end
    end

    if (!take) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TAG;
      idx_r    <= 3'd0;
      total_r  <= 4'd0;
      len_r    <= 64'd0;
      remain_r <= 31'd0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      total_r  <= total_nxt;
      len_r    <= len_nxt;
      remain_r <= remain_nxt;
    end
  end

endmodule

`default_nettype wire
